>>> design/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg: shared types and constants of the partitioned bloom filter
// Request structs, the front-to-back job format and the hash constants.
// ----------------------------------------------------------------------------
package pbf_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_byte;
    logic       last;
  } pbf_in_t;

  typedef struct packed {
    logic present;
    logic was_query;
  } pbf_out_t;

  // one job per completed 16-byte block and/or per key end
  typedef struct packed {
    logic [127:0] blk;
    logic         do_mix;
    logic         do_fin;
    logic         first;
    logic [31:0]  seed;
    logic [31:0]  len;
    logic         mode;
  } pbf_job_t;

  localparam logic [1:0] CFG_FILTER_LENGTH = 2'd0;
  localparam logic [1:0] CFG_NUM_HASHES    = 2'd1;
  localparam logic [1:0] CFG_HASH_SEED     = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [63:0] MM_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] MIX_K1  = 64'h0000000052dce729;
  localparam logic [63:0] MIX_K2  = 64'h0000000038495ab5;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] xsh33(input logic [63:0] x);
    return x ^ (x >> 33);
  endfunction

endpackage

>>> design/pbf_fifo.sv
// ----------------------------------------------------------------------------
// pbf_fifo: small register queue
// Decouples two sides; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module pbf_fifo #(
  parameter int W     = 2,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> design/pbf_front.sv
// ----------------------------------------------------------------------------
// pbf_front: key byte collector
// Gathers key bytes into 16-byte blocks and issues mix and finish jobs.
// ----------------------------------------------------------------------------
module pbf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  pbf_pkg::pbf_in_t  in_data,
  output logic              in_full,
  input  logic [31:0]       seed,
  input  logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output pbf_pkg::pbf_job_t q_data
);
  import pbf_pkg::*;

  logic [7:0]  buf_r [16];
  logic [31:0] len_r, len_nxt, len_inc;
  logic [31:0] seed_r, seed_nxt, seed_use;
  logic        first_r, first_nxt;
  logic        accept, do_mix;
  logic [3:0]  wr_idx, tail;
  logic [127:0] blk;

  assign in_full  = busy | q_full;
  assign accept   = in_push & ~in_full;
  assign wr_idx   = len_r[3:0];
  assign len_inc  = len_r + 32'd1;
  assign tail     = len_inc[3:0];
  assign do_mix   = (tail == 4'd0);
  assign seed_use = (len_r == '0) ? seed : seed_r;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      if (4'(b) == wr_idx) begin
        blk[8*b +: 8] = in_data.key_byte;
      end else if (!do_mix && 4'(b) >= tail) begin
        blk[8*b +: 8] = 8'd0;
      end else begin
        blk[8*b +: 8] = buf_r[b];
      end
    end
  end

  always_comb begin
    q_push        = accept & (do_mix | in_data.last);
    q_data.blk    = blk;
    q_data.do_mix = do_mix;
    q_data.do_fin = in_data.last;
    q_data.first  = first_r;
    q_data.seed   = seed_use;
    q_data.len    = len_inc;
    q_data.mode   = in_data.mode;
    len_nxt       = len_r;
    seed_nxt      = seed_r;
    first_nxt     = first_r;
    if (accept) begin
      len_nxt  = in_data.last ? 32'd0 : len_inc;
      seed_nxt = seed_use;
      if (q_push) begin
        first_nxt = in_data.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      seed_r  <= '0;
      first_r <= 1'b1;
    end else begin
      len_r   <= len_nxt;
      seed_r  <= seed_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[wr_idx] <= in_data.key_byte;
    end
  end

endmodule

>>> design/pbf_back.sv
// ----------------------------------------------------------------------------
// pbf_back: hash lanes, index reduction and bit store
// Runs each job on a shared 32x32 multiplier, a serial remainder unit and
// a bit memory with one write port that is swept clear after reset.
// ----------------------------------------------------------------------------
module pbf_back #(
  parameter int MAX_HASHES  = 8,
  parameter int FILTER_BITS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [10:0]       filter_length,
  input  logic [3:0]        num_hashes,
  input  logic              q_empty,
  input  pbf_pkg::pbf_job_t q_data,
  output logic              q_pop,
  input  logic              o_full,
  output logic              o_push,
  output pbf_pkg::pbf_out_t o_data,
  output logic              clearing
);
  import pbf_pkg::*;

  localparam int DEPTH = MAX_HASHES * FILTER_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int NW    = $clog2(MAX_HASHES + 1);

  typedef enum logic [17:0] {
    S_CLR  = 18'b000000000000000001,
    S_IDLE = 18'b000000000000000010,
    S_MUL  = 18'b000000000000000100,
    S_A2   = 18'b000000000000001000,
    S_B1   = 18'b000000000000010000,
    S_B2   = 18'b000000000000100000,
    S_LS   = 18'b000000000001000000,
    S_M1   = 18'b000000000010000000,
    S_M2   = 18'b000000000100000000,
    S_F1   = 18'b000000001000000000,
    S_F2   = 18'b000000010000000000,
    S_F3   = 18'b000000100000000000,
    S_F4   = 18'b000001000000000000,
    S_F5   = 18'b000010000000000000,
    S_F6   = 18'b000100000000000000,
    S_DIV  = 18'b001000000000000000,
    S_RD   = 18'b010000000000000000,
    S_WB   = 18'b100000000000000000
  } state_t;

  state_t   state_r, state_nxt, ret_r, ret_nxt;
  pbf_job_t job_r, job_nxt;
  logic [63:0] lane_lo_r [MAX_HASHES];
  logic [63:0] lane_hi_r [MAX_HASHES];
  logic [63:0] mx_r, mx_nxt, my_r, my_nxt, acc_r, acc_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [31:0] h_r, h_nxt;
  logic [10:0] rem_r, rem_nxt, flen_r, flen_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [LW-1:0] lane_r, lane_nxt;
  logic [NW-1:0] nh_r, nh_nxt;
  logic        all_set_r, all_set_nxt;
  logic        out_pend_r, out_pend_nxt;
  logic [AW-1:0] clr_r, clr_nxt, addr_r, addr_nxt;
  logic        lane_we;
  logic [63:0] lane_lo_wd, lane_hi_wd;
  logic        mem_we, mem_wd, mem_rd_r;
  logic [AW-1:0] mem_wa;
  logic        mem_r [DEPTH];

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [63:0] lo_in, hi_in, t1, t2;
  logic [11:0] rem_sh;
  logic [16:0] fl_ext;
  logic [4:0]  nh_ext;

  assign clearing = (state_r == S_CLR);

  always_comb begin
    unique case (mstep_r)
      2'd0:    begin ma = mx_r[31:0];  mb = my_r[31:0];  end
      2'd1:    begin ma = mx_r[31:0];  mb = my_r[63:32]; end
      default: begin ma = mx_r[63:32]; mb = my_r[31:0];  end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    lo_in  = job_r.first ? {32'd0, job_r.seed + 32'(lane_r)} : lane_lo_r[lane_r];
    hi_in  = job_r.first ? {32'd0, job_r.seed + 32'(lane_r)} : lane_hi_r[lane_r];
    rem_sh = {rem_r, h_r[31]};
    fl_ext = {6'd0, filter_length};
    nh_ext = {1'b0, num_hashes};
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    job_nxt      = job_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    acc_nxt      = acc_r;
    mstep_nxt    = mstep_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    h_nxt        = h_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    lane_nxt     = lane_r;
    flen_nxt     = flen_r;
    nh_nxt       = nh_r;
    all_set_nxt  = all_set_r;
    out_pend_nxt = out_pend_r;
    clr_nxt      = clr_r;
    addr_nxt     = addr_r;
    lane_we      = 1'b0;
    lane_lo_wd   = x_r;
    lane_hi_wd   = y_r;
    mem_we       = 1'b0;
    mem_wd       = 1'b0;
    mem_wa       = addr_r;
    q_pop        = 1'b0;
    o_push       = 1'b0;
    o_data.present   = (job_r.mode == MODE_QUERY) & all_set_r;
    o_data.was_query = job_r.mode;
    t1           = '0;
    t2           = '0;

    unique case (state_r)
      S_CLR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (out_pend_r) begin
          o_push = ~o_full;
          if (!o_full) begin
            out_pend_nxt = 1'b0;
          end
        end else if (!q_empty) begin
          q_pop       = 1'b1;
          job_nxt     = q_data;
          all_set_nxt = 1'b1;
          lane_nxt    = '0;
          if (filter_length == 11'd0) begin
            flen_nxt = 11'd1;
          end else if (fl_ext > 17'(FILTER_BITS)) begin
            flen_nxt = 11'(FILTER_BITS);
          end else begin
            flen_nxt = filter_length;
          end
          if (num_hashes == 4'd0) begin
            nh_nxt = NW'(1);
          end else if (nh_ext > 5'(MAX_HASHES)) begin
            nh_nxt = NW'(MAX_HASHES);
          end else begin
            nh_nxt = NW'(num_hashes);
          end
          mx_nxt    = q_data.blk[63:0];
          my_nxt    = MM_C1;
          mstep_nxt = 2'd0;
          ret_nxt   = S_A2;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mstep_r == 2'd0) begin
          acc_nxt = prod;
        end else begin
          acc_nxt = acc_r + {prod[31:0], 32'd0};
        end
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd2) begin
          mstep_nxt = 2'd0;
          state_nxt = ret_r;
        end
      end
      S_A2: begin
        mx_nxt    = rotl64(acc_r, 31);
        my_nxt    = MM_C2;
        ret_nxt   = S_B1;
        state_nxt = S_MUL;
      end
      S_B1: begin
        a_nxt     = acc_r;
        mx_nxt    = job_r.blk[127:64];
        my_nxt    = MM_C2;
        ret_nxt   = S_B2;
        state_nxt = S_MUL;
      end
      S_B2: begin
        mx_nxt    = rotl64(acc_r, 33);
        my_nxt    = MM_C1;
        ret_nxt   = S_LS;
        state_nxt = S_MUL;
      end
      S_LS: begin
        b_nxt     = acc_r;
        lane_nxt  = '0;
        state_nxt = job_r.do_mix ? S_M1 : S_F1;
      end
      S_M1: begin
        t1        = rotl64(lo_in ^ a_r, 27) + hi_in;
        x_nxt     = t1 + (t1 << 2) + MIX_K1;
        state_nxt = S_M2;
      end
      S_M2: begin
        t2         = rotl64(hi_in ^ b_r, 31) + x_r;
        lane_we    = 1'b1;
        lane_lo_wd = x_r;
        lane_hi_wd = t2 + (t2 << 2) + MIX_K2;
        if (lane_r == LW'(MAX_HASHES - 1)) begin
          job_nxt.first = 1'b0;
          lane_nxt      = '0;
          if (job_r.do_fin) begin
            a_nxt     = '0;
            b_nxt     = '0;
            state_nxt = S_F1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_M1;
        end
      end
      S_F1: begin
        t1        = lo_in ^ a_r ^ {32'd0, job_r.len};
        t2        = hi_in ^ b_r ^ {32'd0, job_r.len};
        x_nxt     = t1 + t2;
        y_nxt     = t2;
        state_nxt = S_F2;
      end
      S_F2: begin
        y_nxt     = y_r + x_r;
        mx_nxt    = xsh33(x_r);
        my_nxt    = FMIX_C1;
        ret_nxt   = S_F3;
        state_nxt = S_MUL;
      end
      S_F3: begin
        mx_nxt    = xsh33(acc_r);
        my_nxt    = FMIX_C2;
        ret_nxt   = S_F4;
        state_nxt = S_MUL;
      end
      S_F4: begin
        x_nxt     = xsh33(acc_r);
        mx_nxt    = xsh33(y_r);
        my_nxt    = FMIX_C1;
        ret_nxt   = S_F5;
        state_nxt = S_MUL;
      end
      S_F5: begin
        mx_nxt    = xsh33(acc_r);
        my_nxt    = FMIX_C2;
        ret_nxt   = S_F6;
        state_nxt = S_MUL;
      end
      S_F6: begin
        t1        = xsh33(acc_r);
        h_nxt     = x_r[31:0] + t1[31:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, flen_r}) begin
          rem_nxt = 11'(rem_sh - {1'b0, flen_r});
        end else begin
          rem_nxt = rem_sh[10:0];
        end
        h_nxt   = {h_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        addr_nxt  = AW'(int'(lane_r) * FILTER_BITS + int'(rem_r));
        state_nxt = S_WB;
      end
      S_WB: begin
        if (job_r.mode == MODE_INSERT) begin
          mem_we = 1'b1;
          mem_wd = 1'b1;
        end else begin
          all_set_nxt = all_set_r & mem_rd_r;
        end
        if (NW'(lane_r) + NW'(1) == nh_r) begin
          out_pend_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_F1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      ret_r      <= S_IDLE;
      mstep_r    <= '0;
      clr_r      <= '0;
      out_pend_r <= 1'b0;
      lane_r     <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      mstep_r    <= mstep_nxt;
      clr_r      <= clr_nxt;
      out_pend_r <= out_pend_nxt;
      lane_r     <= lane_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    acc_r     <= acc_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    h_r       <= h_nxt;
    rem_r     <= rem_nxt;
    flen_r    <= flen_nxt;
    nh_r      <= nh_nxt;
    all_set_r <= all_set_nxt;
    addr_r    <= addr_nxt;
    if (lane_we) begin
      lane_lo_r[lane_r] <= lane_lo_wd;
      lane_hi_r[lane_r] <= lane_hi_wd;
    end
  end

  // bit store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem_r[addr_nxt];
  end

endmodule

>>> design/partitioned_bloom_filter.sv
// ----------------------------------------------------------------------------
// partitioned_bloom_filter: bloom filter with one partition per hash lane
// Keys arrive a byte per request; each lane hashes the key with its own seed.
// ----------------------------------------------------------------------------
// input channel: push key bytes with mode and last while full is low; one
//   byte per cycle is taken until the job queue fills
// result channel: one request per key, present and was_query, held while
//   empty is low and popped with pop; a stalled receiver holds the back end
//   in idle once its result is waiting, the queues then fill and full rises
// config: write filter_length, num_hashes or hash_seed with cfg_wr_en
// each full 16-byte block in the back end takes a job pop, four multiplies
//   on the shared 32x32 multiplier with their setup states, then the two
//   mix states M1 and M2 for each of the MAX_HASHES lanes
// key end then runs for each lane in use: fmix on the shared multiplier,
//   a serial remainder over the 32 hash bits and a memory read/write
// a key that ends on a block boundary runs the lane mix before the finish
// reset clears the bit store one bit per cycle; full stays high until
//   the sweep is done, config writes are still taken
// ----------------------------------------------------------------------------
module partitioned_bloom_filter #(
  parameter int MAX_HASHES  = 8,
  parameter int FILTER_BITS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  pbf_pkg::pbf_in_t  in_data,
  output logic              in_full,
  input  logic              out_pop,
  output pbf_pkg::pbf_out_t out_data,
  output logic              out_empty,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import pbf_pkg::*;

  logic [10:0] filter_length_r;
  logic [3:0]  num_hashes_r;
  logic [31:0] hash_seed_r;

  logic     clearing, jq_full, jq_push, jq_empty, jq_pop;
  pbf_job_t jq_wdata, jq_rdata;
  logic     oq_full, oq_push;
  pbf_out_t oq_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_length_r <= 11'd128;
      num_hashes_r    <= 4'd5;
      hash_seed_r     <= 32'd131;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FILTER_LENGTH: filter_length_r <= cfg_wdata[10:0];
        CFG_NUM_HASHES:    num_hashes_r    <= cfg_wdata[3:0];
        CFG_HASH_SEED:     hash_seed_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .seed    (hash_seed_r),
    .busy    (clearing),
    .q_full  (jq_full),
    .q_push  (jq_push),
    .q_data  (jq_wdata)
  );

  pbf_fifo #(.W($bits(pbf_job_t)), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .wdata (jq_wdata),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .empty (jq_empty)
  );

  pbf_back #(.MAX_HASHES(MAX_HASHES), .FILTER_BITS(FILTER_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .filter_length (filter_length_r),
    .num_hashes    (num_hashes_r),
    .q_empty       (jq_empty),
    .q_data        (jq_rdata),
    .q_pop         (jq_pop),
    .o_full        (oq_full),
    .o_push        (oq_push),
    .o_data        (oq_wdata),
    .clearing      (clearing)
  );

  pbf_fifo #(.W($bits(pbf_out_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

>>> bench/tb_partitioned_bloom_filter.sv
// ----------------------------------------------------------------------------
// tb_partitioned_bloom_filter: self-checking bench for the bloom filter
// Streams keys as byte requests, insert and query, across several filter
// settings; an in-bench murmur3 predictor supplies the expected answers.
// ----------------------------------------------------------------------------
module tb_partitioned_bloom_filter;
  import pbf_pkg::*;

  localparam int NLANES = 8;
  localparam int NBITS  = 1024;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  pbf_in_t           in_data;
  logic              in_full;
  logic              out_pop;
  pbf_out_t          out_data;
  logic              out_empty;
  logic              cfg_wr_en;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_wdata;

  partitioned_bloom_filter #(.MAX_HASHES(NLANES), .FILTER_BITS(NBITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  bit          filt [NLANES][NBITS];
  logic [63:0] lane_lo [NLANES];
  logic [63:0] lane_hi [NLANES];
  logic [7:0]  blk_bytes [16];
  logic [31:0] cur_len;
  logic [10:0] flen_reg;
  logic [3:0]  nh_reg;
  logic [31:0] seed_reg;

  pbf_in_t  key_reqs [$];
  pbf_out_t answers [$];

  int  errors;
  int  drv_gap;
  int  mon_gap;
  int  hold_left;
  bit  hold_req;
  bit  quiet;

  logic [7:0] pool_b [64][72];
  int         pool_n [64];
  int         pool_cnt;

  function automatic logic [63:0] rol(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] k);
    logic [63:0] v;
    v = k ^ (k >> 33);
    v = v * FMIX_C1;
    v = v ^ (v >> 33);
    v = v * FMIX_C2;
    return v ^ (v >> 33);
  endfunction

  function automatic logic [63:0] gather(input int from, input int count);
    logic [63:0] v;
    v = '0;
    for (int b = 0; b < count; b++) v |= 64'(blk_bytes[(from + b) & 15]) << (8 * b);
    return v;
  endfunction

  task automatic mix_lanes();
    logic [63:0] k1, k2, h1, h2, a, b;
    k1 = gather(0, 8);
    k2 = gather(8, 8);
    for (int i = 0; i < NLANES; i++) begin
      h1 = lane_lo[i];
      h2 = lane_hi[i];
      a = rol(k1 * MM_C1, 31) * MM_C2;
      h1 = (rol(h1 ^ a, 27) + h2) * 64'd5 + MIX_K1;
      b = rol(k2 * MM_C2, 33) * MM_C1;
      h2 = (rol(h2 ^ b, 31) + h1) * 64'd5 + MIX_K2;
      lane_lo[i] = h1;
      lane_hi[i] = h2;
    end
  endtask

  function automatic logic [31:0] lane_digest(input int i, input int tail);
    logic [63:0] h1, h2, k;
    h1 = lane_lo[i];
    h2 = lane_hi[i];
    if (tail > 8) begin
      k = rol(gather(8, tail - 8) * MM_C2, 33) * MM_C1;
      h2 ^= k;
    end
    if (tail > 0) begin
      k = rol(gather(0, tail > 8 ? 8 : tail) * MM_C1, 31) * MM_C2;
      h1 ^= k;
    end
    h1 ^= 64'(cur_len);
    h2 ^= 64'(cur_len);
    h1 += h2;
    h2 += h1;
    h1 = avalanche(h1);
    h2 = avalanche(h2);
    h1 += h2;
    return h1[31:0];
  endfunction

  task automatic predict_filter(input pbf_in_t req);
    int       tail, nh, fl;
    bit       all_set;
    pbf_out_t res;
    logic [31:0] h;
    if (cur_len == 0) begin
      for (int i = 0; i < NLANES; i++) begin
        lane_lo[i] = 64'(seed_reg + 32'(i));
        lane_hi[i] = 64'(seed_reg + 32'(i));
      end
    end
    blk_bytes[cur_len[3:0]] = req.key_byte;
    cur_len++;
    if (cur_len[3:0] == 4'd0) mix_lanes();
    if (req.last) begin
      tail = int'(cur_len[3:0]);
      fl = flen_reg == 0 ? 1 : (flen_reg > NBITS ? NBITS : int'(flen_reg));
      nh = nh_reg == 0 ? 1 : (nh_reg > NLANES ? NLANES : int'(nh_reg));
      all_set = 1'b1;
      for (int i = 0; i < nh; i++) begin
        h = lane_digest(i, tail);
        if (req.mode == MODE_INSERT) filt[i][h % fl] = 1'b1;
        else if (!filt[i][h % fl]) all_set = 1'b0;
      end
      cur_len = 0;
      res.present   = (req.mode == MODE_QUERY) && all_set;
      res.was_query = req.mode;
      answers.push_back(res);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_push && !in_full) predict_filter(in_data);
      if (in_push && in_full) begin
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        drv_gap = $urandom_range(1, 19) - 1;
        in_push <= 1'b0;
      end else if (key_reqs.size() > 0) begin
        in_data <= key_reqs.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      mon_gap = 0;
      hold_left = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %b", out_data);
        end else begin
          pbf_out_t want;
          want = answers.pop_front();
          if (out_data.present !== want.present || out_data.was_query !== want.was_query) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: present exp %b got %b, was_query exp %b got %b",
                       want.present, out_data.present, want.was_query, out_data.was_query);
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = 3000;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        mon_gap = $urandom_range(1, 19) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_FILTER_LENGTH: flen_reg = val[10:0];
      CFG_NUM_HASHES:    nh_reg   = val[3:0];
      CFG_HASH_SEED:     seed_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] fl, input logic [31:0] nh, input logic [31:0] sd);
    write_reg(CFG_FILTER_LENGTH, fl);
    write_reg(CFG_NUM_HASHES, nh);
    write_reg(CFG_HASH_SEED, sd);
  endtask

  // queue one key; only the mode on the last byte counts
  task automatic queue_key(input logic [7:0] kb [72], input int n, input logic md);
    pbf_in_t r;
    for (int j = 0; j < n; j++) begin
      r.key_byte = kb[j];
      r.last     = (j == n - 1);
      r.mode     = r.last ? md : logic'($urandom_range(0, 1));
      key_reqs.push_back(r);
    end
    if (md == MODE_INSERT && pool_cnt < 64) begin
      pool_b[pool_cnt] = kb;
      pool_n[pool_cnt] = n;
      pool_cnt++;
    end
  endtask

  task automatic random_keys(input int nbytes, input int maxlen);
    logic [7:0] kb [72];
    int n, sent, r, p;
    logic md;
    sent = 0;
    while (sent < nbytes) begin
      md = logic'($urandom_range(0, 1));
      if (md == MODE_QUERY && pool_cnt > 0 && $urandom_range(0, 1)) begin
        p = $urandom_range(0, pool_cnt - 1);
        kb = pool_b[p];
        n = pool_n[p];
      end else begin
        r = $urandom_range(0, 9);
        n = r < 7 ? $urandom_range(1, 20) : (r < 9 ? $urandom_range(21, 48)
                                                   : $urandom_range(49, 72));
        if (n > maxlen) n = maxlen;
        for (int j = 0; j < 72; j++) kb[j] = 8'($urandom_range(0, 255));
      end
      queue_key(kb, n, md);
      sent += n;
    end
  endtask

  task automatic drain();
    wait (key_reqs.size() == 0 && !in_push && answers.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    logic [7:0] kb [72];
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    out_pop   = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors    = 0;
    hold_req  = 1'b0;
    quiet     = 1'b0;
    pool_cnt  = 0;
    cur_len   = 0;
    flen_reg  = 11'd128;
    nh_reg    = 4'd5;
    seed_reg  = 32'd131;
    foreach (filt[i, j]) filt[i][j] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, single-byte extremes, tail above eight bytes
    for (int j = 0; j < 72; j++) kb[j] = 8'h00;
    queue_key(kb, 1, MODE_INSERT);
    queue_key(kb, 1, MODE_QUERY);
    kb[0] = 8'hff;
    queue_key(kb, 1, MODE_QUERY);
    queue_key(kb, 1, MODE_INSERT);
    queue_key(kb, 1, MODE_QUERY);
    for (int j = 0; j < 9; j++) kb[j] = 8'(j * 8'h1d + 8'h80);
    queue_key(kb, 9, MODE_INSERT);
    queue_key(kb, 9, MODE_QUERY);
    drain();

    // unknown register index is ignored
    write_reg(CFG_SPARE, 32'hffff_ffff);
    configure(32'd1, 32'd1, 32'd0);
    random_keys(100, 72);
    drain();

    configure(32'd1024, 32'd8, 32'hffff_ffff);
    pool_cnt = 0;
    hold_req <= 1'b1;
    for (int k = 0; k < 40; k++) begin
      kb[0] = 8'($urandom_range(0, 255));
      queue_key(kb, 1, logic'($urandom_range(0, 1)));
    end
    random_keys(60, 72);
    drain();

    configure(32'd0, 32'd0, $urandom);
    pool_cnt = 0;
    random_keys(100, 72);
    drain();

    configure(32'd2047, 32'd15, $urandom);
    pool_cnt = 0;
    random_keys(120, 72);
    drain();

    configure($urandom_range(2, 1023), $urandom_range(2, 7), $urandom);
    pool_cnt = 0;
    random_keys(100, 72);
    quiet = 1'b1;
    random_keys(60, 40);
    drain();

    if (answers.size() != 0) errors++;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
